// ===== src/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Shared widths, character classes, scan modes and status codes.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int LINE_LENGTH = 256;
    localparam int MAX_TOKENS  = 16;

    // Character offsets within a line never reach LINE_LENGTH.
    localparam int POS_W   = $clog2(LINE_LENGTH);
    localparam int CNT_W   = $clog2(MAX_TOKENS + 1);
    localparam int CH_W    = 8;
    localparam int IDX_W   = 4;
    localparam int OFS_W   = 8;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 5;
    localparam int POSX_W  = (POS_W > OFS_W) ? POS_W : OFS_W;
    localparam int CNTX_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_QUOTE = 8'h22;

    typedef logic [1:0] t_class;
    localparam t_class CLS_OTHER = 2'd0;
    localparam t_class CLS_SPACE = 2'd1;
    localparam t_class CLS_QUOTE = 2'd2;
    localparam t_class CLS_END   = 2'd3;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_IDLE   = 2'd0;
    localparam t_mode MODE_WORD   = 2'd1;
    localparam t_mode MODE_QUOTED = 2'd2;
    localparam t_mode MODE_DRAIN  = 2'd3;

    typedef logic [STAT_W-1:0] t_status;
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_QUOTE_IN  = 3'd1;
    localparam t_status ST_UNCLOSED  = 3'd2;
    localparam t_status ST_TOO_MANY  = 3'd3;
    localparam t_status ST_TOO_LONG  = 3'd4;

    // Queue between the classifier and the scanner.
    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);

    typedef struct packed {
        logic                 token_valid;
        logic                 line_done;
        logic [COUNT_W-1:0]   token_count;
        t_status              line_status;
        logic [OFS_W-1:0]     token_length;
        logic [OFS_W-1:0]     token_start;
        logic [IDX_W-1:0]     token_index;
    } t_result;

endpackage

// ===== src/clt_front.sv =====
// ----------------------------------------------------------------------------
// Command line tokenizer front end
// Accepts input words and registers their character class.
// ----------------------------------------------------------------------------
module clt_front import clt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  logic [CH_W-1:0] i_s_axis_tdata,   // [7:0] ch
    input  logic            i_s_axis_tlast,   // line_end
    output logic            o_push,
    output t_class          o_push_class,
    input  logic            i_q_ready
);

    logic   r_valid;
    t_class r_class;
    t_class n_class;

    assign o_s_axis_tready = !r_valid || i_q_ready;
    assign o_push          = r_valid;
    assign o_push_class    = r_class;

    always_comb begin
        if (i_s_axis_tlast) begin
            n_class = CLS_END;
        end else if (i_s_axis_tdata == CH_SPACE) begin
            n_class = CLS_SPACE;
        end else if (i_s_axis_tdata == CH_QUOTE) begin
            n_class = CLS_QUOTE;
        end else begin
            n_class = CLS_OTHER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_class <= n_class;
        end
    end

endmodule

// ===== src/clt_queue.sv =====
// ----------------------------------------------------------------------------
// Command line tokenizer class queue
// Short first-in first-out buffer between classifier and scanner.
// ----------------------------------------------------------------------------
module clt_queue import clt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_class i_push_class,
    output logic   o_ready,
    output logic   o_valid,
    output t_class o_class,
    input  logic   i_pop
);

    t_class          r_mem [QDEPTH];
    logic [QA_W-1:0] r_wr_ptr;
    logic [QA_W-1:0] r_rd_ptr;
    logic [QA_W:0]   r_fill;
    logic            w_push;
    logic            w_pop;

    assign o_ready = (r_fill != (QA_W+1)'(QDEPTH));
    assign o_valid = (r_fill != '0);
    assign o_class = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_class;
        end
    end

endmodule

// ===== src/clt_back.sv =====
// ----------------------------------------------------------------------------
// Command line tokenizer scanner
// Runs the token state machine on queued classes and holds the result word.
// ----------------------------------------------------------------------------
module clt_back import clt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_class  i_q_class,
    output logic    o_pop,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_ready
);

    t_mode              r_mode;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_start;
    logic [CNT_W-1:0]   r_count;
    t_status            r_err;
    logic               r_out_valid;
    t_result            r_out;

    t_mode              n_mode;
    logic [POS_W-1:0]   n_pos;
    logic [POS_W-1:0]   n_start;
    logic [CNT_W-1:0]   n_count;
    t_status            n_err;
    logic               w_fire;
    t_result            w_res;

    logic [POSX_W-1:0]  w_start_x;
    logic [POSX_W-1:0]  w_len_x;
    logic [CNTX_W-1:0]  w_cnt_x;
    logic [CNTX_W-1:0]  w_cnt1_x;
    logic               w_too_long;
    logic               w_too_many;

    assign o_pop    = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign w_start_x  = POSX_W'(r_start);
    assign w_len_x    = POSX_W'(r_pos - r_start);
    assign w_cnt_x    = CNTX_W'(r_count);
    assign w_cnt1_x   = CNTX_W'(r_count + 1'b1);
    assign w_too_long = (r_pos >= POS_W'(LINE_LENGTH - 1));
    assign w_too_many = (r_count >= CNT_W'(MAX_TOKENS));

    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_start = r_start;
        n_count = r_count;
        n_err   = r_err;
        w_fire  = 1'b0;
        w_res   = '0;

        if (o_pop) begin
            if (i_q_class == CLS_END) begin
                w_fire            = 1'b1;
                w_res.line_done   = 1'b1;
                w_res.token_count = w_cnt_x[COUNT_W-1:0];
                if (r_err != ST_OK) begin
                    w_res.line_status = r_err;
                end else if (r_mode == MODE_QUOTED) begin
                    w_res.line_status = ST_UNCLOSED;
                end else if (r_mode == MODE_WORD) begin
                    // The open word closes with the line.
                    w_res.token_valid  = 1'b1;
                    w_res.token_index  = w_cnt_x[IDX_W-1:0];
                    w_res.token_start  = w_start_x[OFS_W-1:0];
                    w_res.token_length = w_len_x[OFS_W-1:0];
                    w_res.token_count  = w_cnt1_x[COUNT_W-1:0];
                end
                n_mode  = MODE_IDLE;
                n_pos   = '0;
                n_start = '0;
                n_count = '0;
                n_err   = ST_OK;
            end else if (r_mode != MODE_DRAIN) begin
                if (w_too_long) begin
                    n_err  = ST_TOO_LONG;
                    n_mode = MODE_DRAIN;
                end else begin
                    n_pos = r_pos + 1'b1;
                    unique case (i_q_class)
                        CLS_SPACE: begin
                            if (r_mode == MODE_WORD) begin
                                w_fire = 1'b1;
                                n_count = r_count + 1'b1;
                                n_mode  = MODE_IDLE;
                            end
                        end
                        CLS_QUOTE: begin
                            if (r_mode == MODE_IDLE) begin
                                if (w_too_many) begin
                                    n_err  = ST_TOO_MANY;
                                    n_mode = MODE_DRAIN;
                                end else begin
                                    n_start = r_pos + 1'b1;
                                    n_mode  = MODE_QUOTED;
                                end
                            end else if (r_mode == MODE_WORD) begin
                                n_err  = ST_QUOTE_IN;
                                n_mode = MODE_DRAIN;
                            end else begin
                                w_fire = 1'b1;
                                n_count = r_count + 1'b1;
                                n_mode  = MODE_IDLE;
                            end
                        end
                        default: begin
                            if (r_mode == MODE_IDLE) begin
                                if (w_too_many) begin
                                    n_err  = ST_TOO_MANY;
                                    n_mode = MODE_DRAIN;
                                end else begin
                                    n_start = r_pos;
                                    n_mode  = MODE_WORD;
                                end
                            end
                        end
                    endcase
                    if (w_fire) begin
                        w_res.token_valid  = 1'b1;
                        w_res.token_index  = w_cnt_x[IDX_W-1:0];
                        w_res.token_start  = w_start_x[OFS_W-1:0];
                        w_res.token_length = w_len_x[OFS_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_pos       <= '0;
            r_start     <= '0;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_count <= n_count;
            r_err   <= n_err;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

endmodule

// ===== src/command_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Command line tokenizer
// Splits a character stream into argument tokens and reports each line.
// ----------------------------------------------------------------------------
// The slave channel takes one character per word; tlast marks the line-end
// word, whose character is ignored. The master channel gives one word for
// each completed token and one for each line end; tuser says that the word
// carries a token and tlast that it closes the line. A plain word still open
// at line end is reported in the same word as the line result.
// The front stage registers each character's class into a four-entry queue;
// the scanner pops one queued class per cycle unless the output register
// holds an unread word, and loads that register. One character per cycle is
// taken for as long as the receiver keeps up. When the receiver stalls, the
// output register holds its word, the queue fills and tready on the slave
// side drops. Synchronous reset empties the queue and the output register
// and returns the scanner to the start of a line with no tokens and no
// error.
// ----------------------------------------------------------------------------
module command_line_tokenizer import clt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  logic [CH_W-1:0] i_s_axis_tdata,   // [7:0] ch
    input  logic            i_s_axis_tlast,   // line_end
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    // [3:0] token_index, [11:4] token_start, [19:12] token_length,
    // [22:20] line_status, [27:23] token_count, [31:28] zero
    output logic [31:0]     o_m_axis_tdata,
    output logic            o_m_axis_tuser,   // token_valid
    output logic            o_m_axis_tlast    // line_done
);

    logic    w_push;
    t_class  w_push_class;
    logic    w_q_ready;
    logic    w_q_valid;
    t_class  w_q_class;
    logic    w_pop;
    t_result w_res;

    clt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_push          (w_push),
        .o_push_class    (w_push_class),
        .i_q_ready       (w_q_ready)
    );

    clt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_class (w_push_class),
        .o_ready      (w_q_ready),
        .o_valid      (w_q_valid),
        .o_class      (w_q_class),
        .i_pop        (w_pop)
    );

    clt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_class (w_q_class),
        .o_pop     (w_pop),
        .o_valid   (o_m_axis_tvalid),
        .o_result  (w_res),
        .i_ready   (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {4'b0000, w_res.token_count, w_res.line_status,
                             w_res.token_length, w_res.token_start,
                             w_res.token_index};
    assign o_m_axis_tuser = w_res.token_valid;
    assign o_m_axis_tlast = w_res.line_done;

endmodule

// ===== dv/command_line_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// Command line tokenizer testbench
// Sends lines one character per word and compares each token and line-end
// word with a cycle-free model of the scanner. The tests cover short
// directed lines, the token limit, the line length limit and random lines.
// The sender pauses in random gaps and the receiver stalls on its own
// pattern.
// ----------------------------------------------------------------------------
module command_line_tokenizer_tb import clt_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 1850;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 16;

    typedef logic [CH_W-1:0] t_char_q[$];
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} t_rx_style;

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [CH_W-1:0]    s_tdata  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [31:0]        m_tdata;
    logic               m_tuser;
    logic               m_tlast;

    // Scanner model state.
    t_mode              scan_mode_q;
    int unsigned        next_pos;
    int unsigned        word_start;
    int unsigned        tok_cnt;
    t_status            line_err;

    t_result            expected_words[$];
    int                 mismatches  = 0;
    int                 items_sent  = 0;
    int                 burst_left  = 0;
    int                 idle_cycles = 0;
    t_rx_style          rx_style    = RX_OPEN;
    int                 rx_left     = 0;
    logic [7:0]         rx_tick     = '0;

    command_line_tokenizer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------
    function automatic void line_reset();
        scan_mode_q = MODE_IDLE;
        next_pos    = 0;
        word_start  = 0;
        tok_cnt     = 0;
        line_err    = ST_OK;
    endfunction

    function automatic void latch_error(input t_status code);
        line_err    = code;
        scan_mode_q = MODE_DRAIN;
    endfunction

    function automatic void close_token(input int unsigned pos, output t_result r);
        r              = '0;
        r.token_valid  = 1'b1;
        r.token_index  = IDX_W'(tok_cnt);
        r.token_start  = OFS_W'(word_start);
        r.token_length = OFS_W'(pos - word_start);
        tok_cnt++;
        scan_mode_q    = MODE_IDLE;
    endfunction

    // Returns 1 when the character produces an output word.
    function automatic bit tokenize_char(input logic [CH_W-1:0] ch, input logic eol,
                                         output t_result r);
        int unsigned pos;
        r = '0;
        if (eol) begin
            r.line_done   = 1'b1;
            r.token_count = COUNT_W'(tok_cnt);
            if (line_err != ST_OK) begin
                r.line_status = line_err;
            end else if (scan_mode_q == MODE_QUOTED) begin
                r.line_status = ST_UNCLOSED;
            end else if (scan_mode_q == MODE_WORD) begin
                r.token_valid  = 1'b1;
                r.token_index  = IDX_W'(tok_cnt);
                r.token_start  = OFS_W'(word_start);
                r.token_length = OFS_W'(next_pos - word_start);
                r.token_count  = COUNT_W'(tok_cnt + 1);
            end
            line_reset();
            return 1'b1;
        end
        if (scan_mode_q == MODE_DRAIN)
            return 1'b0;
        if (next_pos >= LINE_LENGTH - 1) begin
            latch_error(ST_TOO_LONG);
            return 1'b0;
        end
        pos      = next_pos;
        next_pos = pos + 1;
        if (ch == CH_SPACE) begin
            if (scan_mode_q != MODE_WORD)
                return 1'b0;
            close_token(pos, r);
            return 1'b1;
        end
        if (ch == CH_QUOTE) begin
            if (scan_mode_q == MODE_WORD) begin
                latch_error(ST_QUOTE_IN);
                return 1'b0;
            end
            if (scan_mode_q == MODE_QUOTED) begin
                close_token(pos, r);
                return 1'b1;
            end
            if (tok_cnt >= MAX_TOKENS) begin
                latch_error(ST_TOO_MANY);
                return 1'b0;
            end
            word_start  = pos + 1;
            scan_mode_q = MODE_QUOTED;
            return 1'b0;
        end
        if (scan_mode_q == MODE_IDLE) begin
            if (tok_cnt >= MAX_TOKENS) begin
                latch_error(ST_TOO_MANY);
                return 1'b0;
            end
            word_start  = pos;
            scan_mode_q = MODE_WORD;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    function automatic string show(input t_result r);
        return $sformatf("tok=%0d idx=%0d start=%0d len=%0d done=%0d status=%0d count=%0d",
                         r.token_valid, r.token_index, r.token_start, r.token_length,
                         r.line_done, r.line_status, r.token_count);
    endfunction

    function automatic void flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ERROR %s", $time, msg);
    endfunction

    // Handshakes are sampled at the falling edge, where every signal is settled.
    always @(negedge i_clk) begin : out_check
        t_result got;
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.token_valid  = m_tuser;
            got.line_done    = m_tlast;
            got.token_index  = m_tdata[3:0];
            got.token_start  = m_tdata[11:4];
            got.token_length = m_tdata[19:12];
            got.line_status  = m_tdata[22:20];
            got.token_count  = m_tdata[27:23];
            if (expected_words.size() == 0) begin
                flag_error($sformatf("unexpected word: %s", show(got)));
            end else begin
                want = expected_words.pop_front();
                if (got !== want || m_tdata[31:28] !== 4'h0)
                    flag_error($sformatf("word mismatch: expected %s, got %s pad=%h",
                                         show(want), show(got), m_tdata[31:28]));
            end
        end
    end

    always @(negedge i_clk) begin : watchdog
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: picks a new stall style when its current run ends.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_style = t_rx_style'($urandom_range(0, 3));
            rx_left  = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_style)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= (rx_tick[2:0] != 3'd0);
        endcase
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send_char(input logic [CH_W-1:0] ch, input logic eol);
        t_result r;
        bit      took;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eol;
        do begin
            @(negedge i_clk);
            took = s_tready;
            @(posedge i_clk);
        end while (!took);
        if (tokenize_char(ch, eol, r))
            expected_words.push_back(r);
        items_sent++;
    endtask

    task automatic send_line(input t_char_q line);
        foreach (line[i])
            send_char(line[i], 1'b0);
        // The character of the line-end word is ignored, so it is random.
        send_char(CH_W'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [CH_W-1:0] plain_char();
        logic [CH_W-1:0] c;
        do c = CH_W'($urandom_range(0, 255)); while (c == CH_SPACE || c == CH_QUOTE);
        return c;
    endfunction

    function automatic logic [CH_W-1:0] quoted_char();
        logic [CH_W-1:0] c;
        do c = ($urandom_range(0, 4) == 0) ? CH_SPACE : CH_W'($urandom_range(0, 255));
        while (c == CH_QUOTE);
        return c;
    endfunction

    function automatic void add_plain(ref t_char_q l, input int n);
        repeat (n) l.push_back(plain_char());
    endfunction

    function automatic void add_quoted(ref t_char_q l, input int n);
        l.push_back(CH_QUOTE);
        repeat (n) l.push_back(quoted_char());
        l.push_back(CH_QUOTE);
    endfunction

    function automatic t_char_q random_line();
        t_char_q l;
        int      kind;
        int      ntok;
        l    = {};
        kind = $urandom_range(0, 9);
        if (kind >= 8) begin
            // Noise, heavy in separators and quotes.
            repeat ($urandom_range(0, 20)) begin
                case ($urandom_range(0, 4))
                    0:       l.push_back(CH_SPACE);
                    1:       l.push_back(CH_QUOTE);
                    default: l.push_back(CH_W'($urandom_range(0, 255)));
                endcase
            end
            return l;
        end
        repeat ($urandom_range(0, 2)) l.push_back(CH_SPACE);
        ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 6);
        for (int t = 0; t < ntok; t++) begin
            if ($urandom_range(0, 2) == 0) begin
                add_quoted(l, $urandom_range(0, 6));
                if ($urandom_range(0, 1))
                    l.push_back(CH_SPACE);
            end else begin
                add_plain(l, $urandom_range(1, 6));
                repeat ($urandom_range(1, 2)) l.push_back(CH_SPACE);
            end
        end
        // Leave the last word open at line end about half the time.
        if ($urandom_range(0, 1) && l.size() > 0 && l[$] == CH_SPACE)
            void'(l.pop_back());
        if (kind == 6) begin
            add_plain(l, $urandom_range(1, 3));
            l.push_back(CH_QUOTE);
            add_plain(l, $urandom_range(0, 3));
        end else if (kind == 7) begin
            l.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 6)) l.push_back(quoted_char());
        end
        return l;
    endfunction

    task automatic test_directed();
        t_char_q l;
        l = {};
        send_line(l);                                        // empty line
        l = {8'h61};
        send_line(l);                                        // word open at line end
        l = {CH_QUOTE, CH_QUOTE};
        send_line(l);                                        // empty quotes
        l = {8'h78, CH_QUOTE, 8'h79};
        send_line(l);                                        // quote inside a word
        l = {CH_QUOTE, CH_SPACE, 8'h61};
        send_line(l);                                        // unclosed quote
        l = {8'h00, 8'hFF, CH_SPACE};
        send_line(l);                                        // zero and all-ones chars
        l = {CH_SPACE, 8'h62, CH_SPACE, CH_QUOTE, 8'h63, CH_QUOTE, 8'h64};
        send_line(l);                                        // word right after quotes
    endtask

    // Sixteen tokens fill the line; a seventeenth must be refused.
    task automatic test_token_limit();
        t_char_q l;
        for (int k = 0; k < 4; k++) begin
            l = {};
            for (int t = 0; t < MAX_TOKENS; t++) begin
                if (t != MAX_TOKENS - 1 && $urandom_range(0, 1))
                    add_quoted(l, $urandom_range(0, 3));
                else
                    add_plain(l, $urandom_range(1, 3));
                if (t != MAX_TOKENS - 1)
                    l.push_back(CH_SPACE);
            end
            case (k)
                1: begin
                    l.push_back(CH_SPACE);
                    add_plain(l, 2);
                end
                2: begin
                    l.push_back(CH_SPACE);
                    add_quoted(l, 1);
                end
                3: repeat (3) l.push_back(CH_SPACE);
                default: ;
            endcase
            send_line(l);
        end
    endtask

    task automatic test_line_length();
        t_char_q l;
        // Exactly the longest line, ending in an open word.
        l = {};
        add_quoted(l, 120);
        l.push_back(CH_SPACE);
        add_plain(l, LINE_LENGTH - 1 - l.size());
        send_line(l);
        // Six characters too many; the tail after the overflow is dropped.
        l = {};
        add_plain(l, 200);
        l.push_back(CH_SPACE);
        add_plain(l, 60);
        send_line(l);
        // The longest quoted token a line can hold.
        l = {};
        add_quoted(l, LINE_LENGTH - 3);
        send_line(l);
    endtask

    task automatic test_random();
        while (items_sent < ITEM_TARGET)
            send_line(random_line());
    endtask

    initial begin
        line_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_token_limit();
        test_line_length();
        test_random();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
